>>> rtl/core/tmrc_pkg.sv
// Shared types and constants for the tile map rectangle collision block.
package tmrc_pkg;

	// Tile indexes are carried at the widest map size allowed (256 tiles per side).
	localparam int IDX_W = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_QUERY,
		CMD_MISS
	} cmd_kind_t;

	// For a write, top holds the row and left the column.
	typedef struct packed {
		cmd_kind_t        kind;
		logic             solid;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] top;
		logic [IDX_W-1:0] bottom;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} back_state_t;

endpackage

>>> rtl/core/tile_map_rect_collision.sv
// Top level of the tile map rectangle collision block.
// Requests enter on the in channel (in_valid / in_stall). A write request
// (req_type 0) stores whether tile_id is nonzero at tile_row / tile_col and
// gives no response; writes outside the map are dropped. A query request
// (req_type 1) gives one response on the out channel: hit is 1 when any tile
// under the rectangle rect_x, rect_y, rect_w, rect_h is solid.
// The intake turns each rectangle into a clamped tile span in the cycle it is
// accepted and places it in a four-entry queue. The scanner reads the one-bit
// map memory once per cycle along the span and stops at the first solid tile.
// A query wholly off the map skips the scan and goes straight to its response,
// and a write is stored as the scanner takes it from the queue. The scanner
// takes the next command only once it is through with the last one.
// After reset the map memory is cleared one tile per cycle over all
// MAP_ROWS * MAP_COLS tiles (2048 by default); in_stall is high meanwhile.
// When out_stall is high the response waits in the output register while
// further requests are still taken until the queue fills.
module tile_map_rect_collision #(
	parameter int TILE_SHIFT = 5,
	parameter int MAP_COLS   = 64,
	parameter int MAP_ROWS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [4:0]         tile_row,
	input  logic [5:0]         tile_col,
	input  logic [15:0]        tile_id,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [11:0]        rect_w,
	input  logic [11:0]        rect_h,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit
);
	import tmrc_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	logic clearing;

	tmrc_front #(
		.TILE_SHIFT(TILE_SHIFT),
		.MAP_COLS  (MAP_COLS),
		.MAP_ROWS  (MAP_ROWS)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.tile_row(tile_row),
		.tile_col(tile_col),
		.tile_id (tile_id),
		.rect_x  (rect_x),
		.rect_y  (rect_y),
		.rect_w  (rect_w),
		.rect_h  (rect_h),
		.q_full  (q_full),
		.busy    (clearing),
		.push    (push),
		.push_cmd(push_cmd)
	);

	tmrc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	tmrc_back #(
		.MAP_COLS(MAP_COLS),
		.MAP_ROWS(MAP_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head_cmd (head_cmd),
		.pop      (pop),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit)
	);

endmodule

>>> rtl/core/tmrc_front.sv
// Request intake: classifies requests and turns rectangles into clamped tile spans.
module tmrc_front #(
	parameter int TILE_SHIFT = 5,
	parameter int MAP_COLS   = 64,
	parameter int MAP_ROWS   = 32
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [4:0]         tile_row,
	input  logic [5:0]         tile_col,
	input  logic [15:0]        tile_id,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [11:0]        rect_w,
	input  logic [11:0]        rect_h,
	input  logic               q_full,
	input  logic               busy,
	output logic               push,
	output tmrc_pkg::cmd_t     push_cmd
);
	import tmrc_pkg::*;

	localparam int TILE = 1 << TILE_SHIFT;

	logic signed [16:0] xr_sum;
	logic signed [16:0] yb_sum;
	logic [16:0]        xr_mag;
	logic [16:0]        yb_mag;
	logic               right_off;
	logic               bottom_off;
	logic [16:0]        lf_full;
	logic [16:0]        tp_full;
	logic [16:0]        rt_full;
	logic [16:0]        bt_full;
	logic [16:0]        rt_cl;
	logic [16:0]        bt_cl;
	logic               span_empty;
	logic               wr_in_map;

	assign xr_sum = {rect_x[15], rect_x} + $signed({5'b0, rect_w});
	assign yb_sum = {rect_y[15], rect_y} + $signed({5'b0, rect_h});
	assign xr_mag = 17'(-xr_sum);
	assign yb_mag = 17'(-yb_sum);

	// An edge lands on a negative tile only once it is a full tile left of zero,
	// since the division truncates toward zero.
	assign right_off  = xr_sum[16] && (xr_mag >= 17'(TILE));
	assign bottom_off = yb_sum[16] && (yb_mag >= 17'(TILE));

	assign lf_full = rect_x[15] ? 17'd0 : ({2'b0, rect_x[14:0]} >> TILE_SHIFT);
	assign tp_full = rect_y[15] ? 17'd0 : ({2'b0, rect_y[14:0]} >> TILE_SHIFT);
	assign rt_full = xr_sum[16] ? 17'd0 : (17'(xr_sum) >> TILE_SHIFT);
	assign bt_full = yb_sum[16] ? 17'd0 : (17'(yb_sum) >> TILE_SHIFT);

	assign rt_cl = (rt_full > 17'(MAP_COLS - 1)) ? 17'(MAP_COLS - 1) : rt_full;
	assign bt_cl = (bt_full > 17'(MAP_ROWS - 1)) ? 17'(MAP_ROWS - 1) : bt_full;

	assign span_empty = right_off || bottom_off || (lf_full > rt_cl) || (tp_full > bt_cl);

	assign wr_in_map = (9'(tile_row) < 9'(MAP_ROWS)) && (9'(tile_col) < 9'(MAP_COLS));

	assign in_stall = q_full || busy;
	assign push     = in_valid && !in_stall && ((req_type == REQ_QUERY) || wr_in_map);

	always_comb begin
		push_cmd = '0;
		unique case (req_type)
			REQ_WRITE: begin
				push_cmd.kind  = CMD_WRITE;
				push_cmd.solid = |tile_id;
				push_cmd.top   = IDX_W'(tile_row);
				push_cmd.left  = IDX_W'(tile_col);
			end
			REQ_QUERY: begin
				push_cmd.kind   = span_empty ? CMD_MISS : CMD_QUERY;
				push_cmd.left   = lf_full[IDX_W-1:0];
				push_cmd.right  = rt_cl[IDX_W-1:0];
				push_cmd.top    = tp_full[IDX_W-1:0];
				push_cmd.bottom = bt_cl[IDX_W-1:0];
			end
			default: push_cmd = '0;
		endcase
	end

endmodule

>>> rtl/core/tmrc_queue.sv
// Short command queue between the intake and the map scanner.
module tmrc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmrc_pkg::cmd_t push_cmd,
	input  logic           pop,
	output tmrc_pkg::cmd_t head_cmd,
	output logic           full,
	output logic           empty
);
	import tmrc_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

>>> rtl/core/tmrc_back.sv
// Map scanner: holds the solid map, clears it after reset, runs writes and span scans.
module tmrc_back #(
	parameter int MAP_COLS = 64,
	parameter int MAP_ROWS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  tmrc_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           clearing,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           hit
);
	import tmrc_pkg::*;

	localparam int CELLS  = MAP_ROWS * MAP_COLS;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	// Only whether a tile is solid matters, so one bit per tile is kept.
	logic mem [CELLS];

	back_state_t      state_q;
	back_state_t      state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [IDX_W-1:0]  left_q;
	logic [IDX_W-1:0]  right_q;
	logic [IDX_W-1:0]  bottom_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic              issue_done_q;
	logic              pend_q;
	logic              pend_last_q;
	logic              rd_data_q;
	logic              found_q;
	logic              out_valid_q;
	logic              hit_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              at_last;
	logic              out_load;
	logic              clr_last;

	assign clr_last = (clr_addr_q == ADDR_W'(CELLS - 1));
	assign at_last  = (row_q == bottom_q) && (col_q == right_q);
	assign rd_addr  = ADDR_W'(row_q * MAP_COLS + col_q);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign clearing  = (state_q == ST_CLEAR);
	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(head_cmd.top * MAP_COLS + head_cmd.left);
		wr_data = head_cmd.solid;
		rd_en   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = 1'b0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (head_cmd.kind)
						CMD_WRITE: wr_en = 1'b1;
						CMD_QUERY: state_d = ST_SCAN;
						CMD_MISS:  state_d = ST_DONE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = !issue_done_q;
				if (pend_q && (rd_data_q || pend_last_q)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			issue_done_q <= 1'b0;
			pend_q       <= 1'b0;
			pend_last_q  <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (pop) begin
				issue_done_q <= 1'b0;
				pend_q       <= 1'b0;
				pend_last_q  <= 1'b0;
				found_q      <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_q      <= rd_en;
				pend_last_q <= at_last;
				if (rd_en && at_last) begin
					issue_done_q <= 1'b1;
				end
				if (pend_q && rd_data_q) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Span registers, the scan position and the hit register; walks the span row by row.
	always_ff @(posedge clk) begin
		if (pop) begin
			left_q   <= head_cmd.left;
			right_q  <= head_cmd.right;
			bottom_q <= head_cmd.bottom;
			row_q    <= head_cmd.top;
			col_q    <= head_cmd.left;
		end else if (rd_en) begin
			if (col_q == right_q) begin
				col_q <= left_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
		if (out_load) begin
			hit_q <= found_q;
		end
	end

endmodule

>>> tb/tmrc_hit_checker.sv
// Checker for the tile map collision block: mirrors the map and scores every hit response.
module tmrc_hit_checker #(
	parameter int TILE_SHIFT = 5,
	parameter int MAP_COLS   = 64,
	parameter int MAP_ROWS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               req_type,
	input  logic [4:0]         tile_row,
	input  logic [5:0]         tile_col,
	input  logic [15:0]        tile_id,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [11:0]        rect_w,
	input  logic [11:0]        rect_h,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               hit,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tmrc_pkg::*;

	localparam int TILE_PX = 1 << TILE_SHIFT;

	// Only whether a tile id is nonzero matters for a query.
	logic solid_tiles [MAP_ROWS][MAP_COLS];
	logic expected_hits [$];
	int   mismatches = 0;
	int   responses_seen = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: response %0d: %s", $time, responses_seen, what);
		mismatches++;
	endtask

	function automatic logic rect_hits_solid(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [11:0] w, input logic [11:0] h);
		int   left;
		int   right;
		int   top;
		int   bottom;
		logic found;
		found = 1'b0;
		// Integer division on int truncates toward zero, so small negative edges land on tile 0.
		left = int'(x) / TILE_PX;
		right = (int'(x) + int'(w)) / TILE_PX;
		top = int'(y) / TILE_PX;
		bottom = (int'(y) + int'(h)) / TILE_PX;
		if (left < 0)
			left = 0;
		if (top < 0)
			top = 0;
		if (right > MAP_COLS - 1)
			right = MAP_COLS - 1;
		if (bottom > MAP_ROWS - 1)
			bottom = MAP_ROWS - 1;
		for (int r = top; r <= bottom; r++)
			for (int c = left; c <= right; c++)
				if (solid_tiles[r][c])
					found = 1'b1;
		return found;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			foreach (solid_tiles[r, c])
				solid_tiles[r][c] = 1'b0;
			expected_hits.delete();
		end else begin
			// Retire a response before taking a new request, so a response can never
			// be matched against a query accepted on the same edge.
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				responses_seen++;
				if (expected_hits.size() == 0) begin
					report_mismatch($sformatf("hit=%0b arrived with no query waiting", hit));
				end else begin
					want = expected_hits.pop_front();
					if (hit !== want)
						report_mismatch($sformatf("hit=%0b, expected %0b", hit, want));
				end
			end
			if (in_valid == 1'b1 && in_stall === 1'b0) begin
				if (req_type == REQ_WRITE) begin
					if (tile_row < MAP_ROWS && tile_col < MAP_COLS)
						solid_tiles[tile_row][tile_col] = (tile_id != 16'd0);
				end else begin
					expected_hits.push_back(rect_hits_solid(rect_x, rect_y, rect_w, rect_h));
				end
			end
		end
		fail_count <= mismatches;
		pending <= expected_hits.size();
	end

endmodule

>>> tb/tb.sv
// Top of the testbench: clock, reset, request stimulus, receiver stalls and the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmrc_pkg::*;

	localparam int TILE_SHIFT     = 5;
	localparam int MAP_COLS       = 64;
	localparam int MAP_ROWS       = 32;
	localparam int RANDOM_REQS    = 1130;
	localparam int HOLD_CYCLES    = 1500;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic               req_type;
		logic [4:0]         row;
		logic [5:0]         col;
		logic [15:0]        id;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [11:0]        w;
		logic [11:0]        h;
	} tile_req_t;

	localparam int REQ_W = $bits(tile_req_t);

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic [4:0]         tile_row;
	logic [5:0]         tile_col;
	logic [15:0]        tile_id;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [11:0]        rect_w;
	logic [11:0]        rect_h;
	logic               out_valid;
	logic               out_stall;
	logic               hit;

	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	int   burst_left = 4;
	logic hold_go = 1'b0;

	tile_map_rect_collision #(
		.TILE_SHIFT(TILE_SHIFT),
		.MAP_COLS(MAP_COLS),
		.MAP_ROWS(MAP_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.tile_row(tile_row),
		.tile_col(tile_col),
		.tile_id(tile_id),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit)
	);

	tmrc_hit_checker #(
		.TILE_SHIFT(TILE_SHIFT),
		.MAP_COLS(MAP_COLS),
		.MAP_ROWS(MAP_ROWS)
	) hit_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.tile_row(tile_row),
		.tile_col(tile_col),
		.tile_id(tile_id),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Fields that a request kind does not use carry random values.
	function automatic tile_req_t write_req(input logic [4:0] row, input logic [5:0] col,
			input logic [15:0] id);
		tile_req_t r;
		r = tile_req_t'(REQ_W'({$urandom, $urandom, $urandom}));
		r.req_type = REQ_WRITE;
		r.row = row;
		r.col = col;
		r.id = id;
		return r;
	endfunction

	function automatic tile_req_t query_req(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [11:0] w, input logic [11:0] h);
		tile_req_t r;
		r = tile_req_t'(REQ_W'({$urandom, $urandom, $urandom}));
		r.req_type = REQ_QUERY;
		r.x = x;
		r.y = y;
		r.w = w;
		r.h = h;
		return r;
	endfunction

	task automatic drive_req(input tile_req_t r);
		in_valid <= 1'b1;
		req_type <= r.req_type;
		tile_row <= r.row;
		tile_col <= r.col;
		tile_id <= r.id;
		rect_x <= r.x;
		rect_y <= r.y;
		rect_w <= r.w;
		rect_h <= r.h;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
		end
	endtask

	initial begin
		tile_req_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		tile_row = '0;
		tile_col = '0;
		tile_id = '0;
		rect_x = '0;
		rect_y = '0;
		rect_w = '0;
		rect_h = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: map corners, field extremes, negative edges and spans off the map.
		drive_req(write_req(5'd0, 6'd0, 16'hFFFF));
		drive_req(write_req(5'd31, 6'd63, 16'h0001));
		drive_req(write_req(5'd15, 6'd32, 16'h8000));
		drive_req(query_req(16'sd0, 16'sd0, 12'd0, 12'd0));
		drive_req(query_req(-16'sd31, -16'sd1, 12'd0, 12'd0));
		drive_req(query_req(-16'sd32, -16'sd32, 12'd0, 12'd0));
		drive_req(query_req(16'sd2016, 16'sd992, 12'd31, 12'd31));
		drive_req(query_req(16'sd32767, 16'sd32767, 12'hFFF, 12'hFFF));
		drive_req(query_req(-16'sd32768, -16'sd32768, 12'hFFF, 12'hFFF));
		drive_req(query_req(16'sd2048, 16'sd0, 12'd0, 12'd0));
		drive_req(query_req(16'sd0, 16'sd1024, 12'd0, 12'd0));
		drive_req(query_req(16'sd1000, 16'sd470, 12'd40, 12'd40));
		drive_req(write_req(5'd0, 6'd0, 16'h0000));
		drive_req(write_req(5'd31, 6'd63, 16'h0000));
		drive_req(query_req(16'sd0, 16'sd0, 12'hFFF, 12'hFFF));
		drive_req(query_req(-16'sd32768, 16'sd480, 12'hFFF, 12'd0));
		drive_req(write_req(5'd15, 6'd32, 16'h0000));
		drive_req(query_req(16'sd0, 16'sd0, 12'hFFF, 12'hFFF));
		drive_req(write_req(5'd31, 6'd0, 16'h5A5A));
		drive_req(query_req(-16'sd1, 16'sd1023, 12'd0, 12'd0));

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == 40)
				hold_go <= 1'b1;
			if ($urandom_range(0, 1) == 0) begin
				drive_req(write_req(5'($urandom), 6'($urandom),
					($urandom_range(0, 9) < 3) ? 16'd0 : 16'($urandom)));
			end else begin
				// Mostly small rectangles near the map; now and then any edge or a huge extent.
				r = query_req(
					($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2200) - 64),
					($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1150) - 64),
					($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 96)),
					($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 96)));
				drive_req(r);
			end
		end
		in_valid <= 1'b0;

		// Let the checker's count take in the last accepted request first.
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Receiver: stall density changes from stretch to stretch, with one long hold-off.
	initial begin
		int   mode;
		logic hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				if (hold_go && !hold_done) begin
					hold_done = 1'b1;
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else if (mode == 0) begin
					out_stall <= 1'b0;
				end else if (mode == 1) begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end else begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid == 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall == 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
